// ===== hdl/ctts_pkg.sv =====
// ----------------------------------------------------------------------------
// ctts_pkg
// Shared types, codes and constants of the cooperative tick scheduler.
// ----------------------------------------------------------------------------
package ctts_pkg;

    // Table geometry
    localparam int TASK_SLOTS_DEF = 8;
    localparam int MAX_RESULTS    = 8;
    localparam int RES_CNT_W      = $clog2(MAX_RESULTS);

    // Field widths
    localparam int CMD_W   = 2;
    localparam int TASK_W  = 8;
    localparam int TIME_W  = 16;
    localparam int PEND_W  = 8;
    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 3;

    localparam logic [PEND_W-1:0] PENDING_MAX = {PEND_W{1'b1}};

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    // One table entry as stored in the slot memory
    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] period;
        logic [PEND_W-1:0] pending;
    } slot_entry_t;

    // Operation of the shared slot update unit
    typedef enum logic {
        ALU_TICK,
        ALU_RUN
    } alu_op_t;

endpackage

// ===== hdl/ctts_ram.sv =====
// ----------------------------------------------------------------------------
// ctts_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ctts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read; read data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/ctts_slot_alu.sv =====
// ----------------------------------------------------------------------------
// ctts_slot_alu
// Shared slot update unit: timer tick countdown/release and run consume.
// ----------------------------------------------------------------------------
module ctts_slot_alu (
    input  ctts_pkg::alu_op_t     op,
    input  ctts_pkg::slot_entry_t entry_in,
    output ctts_pkg::slot_entry_t entry_out
);

    always_comb
    begin
        entry_out = entry_in;
        unique case (op)
            ctts_pkg::ALU_TICK:
            begin
                // Release on zero delay, else count down
                if (entry_in.delay == '0)
                begin
                    if (entry_in.pending != ctts_pkg::PENDING_MAX)
                    begin
                        entry_out.pending = entry_in.pending + 1'b1;
                    end
                    if (entry_in.period != '0)
                    begin
                        entry_out.delay = entry_in.period;
                    end
                end
                else
                begin
                    entry_out.delay = entry_in.delay - 1'b1;
                end
            end
            ctts_pkg::ALU_RUN:
            begin
                // Consume one pending run
                entry_out.pending = entry_in.pending - 1'b1;
            end
            default:
            begin
                entry_out = entry_in;
            end
        endcase
    end

endmodule

// ===== hdl/cooperative_task_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// cooperative_task_tick_scheduler
// Time-triggered cooperative scheduler over a table of task slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one command item: add a task,
//   timer tick, or dispatch. in_stall is high while a command is in work.
//   Output channel (out_valid/out_stall) carries result items; the final
//   result of a command has last set. Add and tick give one result each,
//   dispatch gives one result per ready slot (at most 8) or one
//   nothing-ready result.
// Sequencing per command:
//   add      : the free slot comes from a priority encoder.
//   tick     : the slot memory is read and written back one slot per cycle
//              through the shared update unit.
//   dispatch : skipped slots are stepped over; each dispatched slot has a
//              memory read, then update and result, up to the last ready
//              slot.
// Reset clears the occupancy and ready flags at once; slot memory contents
// are only used for occupied slots. A stall on the output holds the result
// register and pauses the sequencer when it next has a result to deliver.
// ----------------------------------------------------------------------------
module cooperative_task_tick_scheduler #(
    parameter int TASK_SLOTS = ctts_pkg::TASK_SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Command channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ctts_pkg::CMD_W-1:0]    command,
    input  logic [ctts_pkg::TASK_W-1:0]   task_id,
    input  logic [ctts_pkg::TIME_W-1:0]   period,
    input  logic [ctts_pkg::TIME_W-1:0]   initial_delay,
    // Result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ctts_pkg::KIND_W-1:0]   kind,
    output logic [ctts_pkg::TASK_W-1:0]   task_id_out,
    output logic [ctts_pkg::SLOT_W-1:0]   slot,
    output logic                          table_full,
    output logic                          last
);

    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W = $clog2(TASK_SLOTS + 1);
    localparam int ENT_W = $bits(ctts_pkg::slot_entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_DSCAN,
        ST_DREAD,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;

    // Slot flags in flip-flops
    logic [TASK_SLOTS-1:0] used_reg, used_next;
    logic [TASK_SLOTS-1:0] ready_reg, ready_next;

    // Sequencer counters
    logic [CNT_W-1:0]               idx_reg, idx_next;
    logic [IDX_W-1:0]               p_idx_reg, p_idx_next;
    logic                           p_vld_reg, p_vld_next;
    logic [ctts_pkg::RES_CNT_W-1:0] n_reg, n_next;

    // Pending single-result payload
    logic [ctts_pkg::KIND_W-1:0]    resp_kind_reg, resp_kind_next;
    logic [ctts_pkg::TASK_W-1:0]    resp_task_reg, resp_task_next;
    logic [ctts_pkg::SLOT_W-1:0]    resp_slot_reg, resp_slot_next;
    logic                           resp_full_reg, resp_full_next;

    // Output register
    logic                           out_valid_reg, out_valid_next;
    logic [ctts_pkg::KIND_W-1:0]    kind_reg, kind_next;
    logic [ctts_pkg::TASK_W-1:0]    task_reg, task_next;
    logic [ctts_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic                           full_reg, full_next;
    logic                           last_reg, last_next;

    // Memory and update unit
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    ctts_pkg::slot_entry_t ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    ctts_pkg::slot_entry_t ram_rdata;
    ctts_pkg::alu_op_t     alu_op;
    ctts_pkg::slot_entry_t alu_out;

    logic             in_take;
    logic             out_free;
    logic [IDX_W-1:0] cur_idx;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             more_ready;

    ctts_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TASK_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    ctts_slot_alu u_slot_alu (
        .op        (alu_op),
        .entry_in  (ram_rdata),
        .entry_out (alu_out)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign cur_idx  = idx_reg[IDX_W-1:0];

    // First free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TASK_SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Any ready slot beyond the current one
    always_comb
    begin
        more_ready = 1'b0;
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            if (CNT_W'(i) > idx_reg)
            begin
                more_ready = more_ready | ready_reg[i];
            end
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        ready_next     = ready_reg;
        idx_next       = idx_reg;
        p_idx_next     = p_idx_reg;
        p_vld_next     = 1'b0;
        n_next         = n_reg;
        resp_kind_next = resp_kind_reg;
        resp_task_next = resp_task_reg;
        resp_slot_next = resp_slot_reg;
        resp_full_next = resp_full_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        task_next      = task_reg;
        slot_next      = slot_reg;
        full_next      = full_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        alu_op         = ctts_pkg::ALU_TICK;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    unique case (command)
                        ctts_pkg::CMD_ADD:
                        begin
                            // Place task in first free slot, or flag full
                            resp_kind_next = ctts_pkg::KIND_ADD;
                            resp_task_next = task_id;
                            resp_slot_next = '0;
                            resp_full_next = !free_found;
                            if (free_found)
                            begin
                                ram_we            = 1'b1;
                                ram_waddr         = free_idx;
                                ram_wdata.task_id = task_id;
                                ram_wdata.delay   = initial_delay;
                                ram_wdata.period  = period;
                                ram_wdata.pending = '0;
                                used_next[free_idx]  = 1'b1;
                                ready_next[free_idx] = 1'b0;
                                resp_slot_next = ctts_pkg::SLOT_W'(free_idx);
                            end
                            state_next = ST_RESP;
                        end
                        ctts_pkg::CMD_TICK:
                        begin
                            idx_next   = '0;
                            state_next = ST_TICK;
                        end
                        ctts_pkg::CMD_DISPATCH:
                        begin
                            idx_next = '0;
                            n_next   = '0;
                            if (ready_reg == '0)
                            begin
                                resp_kind_next = ctts_pkg::KIND_NONE;
                                resp_task_next = '0;
                                resp_slot_next = '0;
                                resp_full_next = 1'b0;
                                state_next     = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_DSCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_TICK:
            begin
                // Read slot idx while writing back slot idx-1
                if (idx_reg < CNT_W'(TASK_SLOTS))
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = cur_idx;
                    p_vld_next = 1'b1;
                    p_idx_next = cur_idx;
                    idx_next   = idx_reg + CNT_W'(1);
                end
                if (p_vld_reg)
                begin
                    alu_op = ctts_pkg::ALU_TICK;
                    if (used_reg[p_idx_reg])
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = p_idx_reg;
                        ram_wdata = alu_out;
                        ready_next[p_idx_reg] = (alu_out.pending != '0);
                    end
                end
                if (!(idx_reg < CNT_W'(TASK_SLOTS)) && !p_vld_reg)
                begin
                    resp_kind_next = ctts_pkg::KIND_TICK;
                    resp_task_next = '0;
                    resp_slot_next = '0;
                    resp_full_next = 1'b0;
                    state_next     = ST_RESP;
                end
            end

            ST_DSCAN:
            begin
                // Step to the next ready slot
                if (!(idx_reg < CNT_W'(TASK_SLOTS)))
                begin
                    state_next = ST_IDLE;
                end
                else if (ready_reg[cur_idx])
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = cur_idx;
                    state_next = ST_DREAD;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            ST_DREAD:
            begin
                // Emit run result; consume one pending run, or free the slot if period is zero
                alu_op = ctts_pkg::ALU_RUN;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = ctts_pkg::KIND_RUN;
                    task_next      = ram_rdata.task_id;
                    slot_next      = ctts_pkg::SLOT_W'(cur_idx);
                    full_next      = 1'b0;
                    last_next      = !more_ready ||
                                     (n_reg == ctts_pkg::RES_CNT_W'(ctts_pkg::MAX_RESULTS - 1));
                    if (ram_rdata.period == '0)
                    begin
                        used_next[cur_idx]  = 1'b0;
                        ready_next[cur_idx] = 1'b0;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = cur_idx;
                        ram_wdata = alu_out;
                        ready_next[cur_idx] = (alu_out.pending != '0);
                    end
                    n_next   = n_reg + ctts_pkg::RES_CNT_W'(1);
                    idx_next = idx_reg + CNT_W'(1);
                    state_next = last_next ? ST_IDLE : ST_DSCAN;
                end
            end

            ST_RESP:
            begin
                // Deliver the single result of this command
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = resp_kind_reg;
                    task_next      = resp_task_reg;
                    slot_next      = resp_slot_reg;
                    full_next      = resp_full_reg;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            ready_reg     <= '0;
            idx_reg       <= '0;
            p_vld_reg     <= 1'b0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            ready_reg     <= ready_next;
            idx_reg       <= idx_next;
            p_vld_reg     <= p_vld_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        p_idx_reg     <= p_idx_next;
        resp_kind_reg <= resp_kind_next;
        resp_task_reg <= resp_task_next;
        resp_slot_reg <= resp_slot_next;
        resp_full_reg <= resp_full_next;
        kind_reg      <= kind_next;
        task_reg      <= task_next;
        slot_reg      <= slot_next;
        full_reg      <= full_next;
        last_reg      <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign task_id_out = task_reg;
    assign slot        = slot_reg;
    assign table_full  = full_reg;
    assign last        = last_reg;

`ifndef ASSERT_OFF
    // A slot with pending runs is always occupied
    a_ready_used: assert property (@(posedge clk) disable iff (!rst_n)
        (ready_reg & ~used_reg) == '0)
        else $error("ready flag set on a free slot");

    // A known command leaves idle on the next cycle
    a_cmd_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && (command == ctts_pkg::CMD_ADD || command == ctts_pkg::CMD_TICK ||
                     command == ctts_pkg::CMD_DISPATCH))
        |=> state_reg != ST_IDLE)
        else $error("accepted command did not start");

    // Dispatch only reads slots that are ready
    a_dread_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DREAD) |-> ready_reg[cur_idx])
        else $error("dispatch on a slot without pending runs");

    // Only run results can be followed by more results
    a_not_last_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> (kind_reg == ctts_pkg::KIND_RUN))
        else $error("non-final result of a single-result command");
`endif

endmodule
